FILE: hw/rtl/msr_pkg.sv
`timescale 1ns / 1ps
// Shared constants and code-unit classifiers for the Myanmar syllable reorder unit.
// No dependencies.
package msr_pkg;

  localparam int SYL_DEPTH = 16;
  localparam int SYL_AW    = (SYL_DEPTH > 1) ? $clog2(SYL_DEPTH) : 1;
  localparam int SYL_CW    = $clog2(SYL_DEPTH + 1);

  localparam logic [15:0] U_BLOCK_LO  = 16'h1000;
  localparam logic [15:0] U_CONS_HI   = 16'h102A;
  localparam logic [15:0] U_GREAT_SA  = 16'h103F;
  localparam logic [15:0] U_DIGIT_LO  = 16'h1040;
  localparam logic [15:0] U_DIGIT_HI  = 16'h1049;
  localparam logic [15:0] U_SYM_AFORE = 16'h104E;
  localparam logic [15:0] U_BLOCK_HI  = 16'h109F;
  localparam logic [15:0] U_E_VOWEL   = 16'h1031;
  localparam logic [15:0] U_MEDIAL_RA = 16'h103C;
  localparam logic [15:0] U_NGA       = 16'h1004;
  localparam logic [15:0] U_ASAT      = 16'h103A;
  localparam logic [15:0] U_VIRAMA    = 16'h1039;

  function automatic logic is_consonant(input logic [15:0] u);
    return ((u >= U_BLOCK_LO) && (u <= U_CONS_HI)) || (u == U_GREAT_SA) ||
           ((u >= U_DIGIT_LO) && (u <= U_DIGIT_HI)) || (u == U_SYM_AFORE);
  endfunction

  function automatic logic is_myanmar(input logic [15:0] u);
    return (u >= U_BLOCK_LO) && (u <= U_BLOCK_HI);
  endfunction

  // kinzi is sent as nga, asat, virama
  function automatic logic [15:0] kinzi_unit(input logic [1:0] idx);
    logic [15:0] r;
    unique case (idx)
      2'd0:    r = U_NGA;
      2'd1:    r = U_ASAT;
      default: r = U_VIRAMA;
    endcase
    return r;
  endfunction

endpackage

FILE: hw/rtl/myanmar_syllable_reorder_unit.sv
`timescale 1ns / 1ps
// Myanmar syllable reorder unit: window, prefix and syllable sequencer.
// Depends on msr_pkg and msr_ram (syllable body store).
//
// Usage:
//   Input channel item_valid/item_ready carries code_unit and end_of_text.
//   Output channel result_valid/result_ready carries out_unit, last_of_run
//   and text_done. One input beat yields zero or more output beats; the last
//   beat caused by an input has last_of_run set, and text_done as well when
//   that input had end_of_text.
//   An input that only fills the lookahead window is just accepted. An input
//   that decides a unit passes accept, decide, act, advance and finish. A
//   syllable flush adds the prefix slot and, per body unit, one store read
//   and one emit; a flush on a full store adds a further act step, and a
//   kinzi repeats the act step for each of its units. At end of text each
//   further window unit passes decide, act and advance, and the closing flush
//   runs as any other flush. The body store is a one-read-port RAM.
//   One result is held back until the next is known, so that last_of_run can
//   be marked; the output register lets the next input be taken while the
//   final result of a beat still waits.
//   Reset (rst, synchronous) empties window, prefix and syllable; the store
//   itself is not cleared. A stalled receiver simply holds the sequencer.
module myanmar_syllable_reorder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  logic [15:0] code_unit,
  input  logic        end_of_text,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [15:0] out_unit,
  output logic        last_of_run,
  output logic        text_done
);
  import msr_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DECIDE, ST_FLUSH_PRE, ST_FLUSH_RD, ST_FLUSH_EMIT, ST_ACT, ST_NEXT, ST_FINAL
  } state_t;

  state_t state;

  logic [15:0]       la0, la1;
  logic [1:0]        la_cnt;
  logic [15:0]       prev_unit;
  logic              prev_valid;
  logic [15:0]       pre_unit;
  logic              pre_valid;
  logic [SYL_CW-1:0] syl_cnt;
  logic [SYL_AW-1:0] rd_idx;
  logic [15:0]       w0, w1, w2;
  logic [1:0]        wn;
  logic              end_flag;
  logic              ret_final;
  logic              force_append;
  logic [1:0]        kz_idx;
  logic [15:0]       pend_unit;
  logic              pend_valid;

  logic              ram_we, ram_re;
  logic [15:0]       ram_rdata;

  logic              adv, can_emit, emit_req, emit_go, fin_go;
  logic [15:0]       emit_data;
  logic              u_foreign, u_cons, u_kinzi, u_boundary, u_prefix, syl_full, rd_last;

  msr_ram #(.WIDTH(16), .DEPTH(SYL_DEPTH)) u_syl_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (syl_cnt[SYL_AW-1:0]),
    .wdata (w0),
    .re    (ram_re),
    .raddr (rd_idx),
    .rdata (ram_rdata)
  );

  always_comb begin
    u_foreign  = !is_myanmar(w0);
    u_cons     = is_consonant(w0);
    u_kinzi    = (w0 == U_NGA) && (wn == 2'd3) && (w1 == U_ASAT) && (w2 == U_VIRAMA);
    // boundary: e-vowel, medial ra, or a free consonant (not kinzi/stacked/killed)
    u_boundary = (w0 == U_E_VOWEL) || (w0 == U_MEDIAL_RA) ||
                 (u_cons && !u_kinzi && !(prev_valid && (prev_unit == U_VIRAMA)) &&
                  !((wn >= 2'd2) && (w1 == U_ASAT)));
    u_prefix   = u_cons && !pre_valid && !force_append;
    syl_full   = (syl_cnt == SYL_CW'(SYL_DEPTH));
    rd_last    = ((SYL_CW'(rd_idx) + SYL_CW'(1)) == syl_cnt);

    adv      = !result_valid || result_ready;
    can_emit = !pend_valid || adv;

    emit_req  = 1'b0;
    emit_data = w0;
    ram_re    = (state == ST_FLUSH_RD);
    ram_we    = 1'b0;
    unique case (state)
      ST_FLUSH_PRE: begin
        emit_req  = pre_valid;
        emit_data = pre_unit;
      end
      ST_FLUSH_EMIT: begin
        emit_req  = 1'b1;
        emit_data = ram_rdata;
      end
      ST_ACT: begin
        if (u_foreign) begin
          emit_req = 1'b1;
        end else if (u_kinzi) begin
          emit_req  = 1'b1;
          emit_data = kinzi_unit(kz_idx);
        end else if (!u_prefix && !syl_full) begin
          ram_we = 1'b1;
        end
      end
      default: ;
    endcase
    emit_go = emit_req && can_emit;
    fin_go  = (state == ST_FINAL) && pend_valid && adv;
  end

  assign item_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      la_cnt       <= '0;
      prev_unit    <= '0;
      prev_valid   <= 1'b0;
      pre_valid    <= 1'b0;
      syl_cnt      <= '0;
      pend_valid   <= 1'b0;
      result_valid <= 1'b0;
      force_append <= 1'b0;
      kz_idx       <= '0;
      ret_final    <= 1'b0;
    end else begin
      // output side: held result moves out when a newer one arrives or the run ends
      if (emit_go) begin
        pend_unit  <= emit_data;
        pend_valid <= 1'b1;
      end
      if (emit_go && pend_valid) begin
        result_valid <= 1'b1;
        out_unit     <= pend_unit;
        last_of_run  <= 1'b0;
        text_done    <= 1'b0;
      end else if (fin_go) begin
        result_valid <= 1'b1;
        out_unit     <= pend_unit;
        last_of_run  <= 1'b1;
        text_done    <= end_flag;
        pend_valid   <= 1'b0;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (item_valid) begin
            end_flag <= end_of_text;
            wn       <= la_cnt + 2'd1;
            unique case (la_cnt)
              2'd0: w0 <= code_unit;
              2'd1: begin
                w0 <= la0;
                w1 <= code_unit;
              end
              default: begin
                w0 <= la0;
                w1 <= la1;
                w2 <= code_unit;
              end
            endcase
            if (end_of_text || (la_cnt == 2'd2)) begin
              state <= ST_DECIDE;
            end else begin
              if (la_cnt == 2'd0) begin
                la0 <= code_unit;
              end else begin
                la1 <= code_unit;
              end
              la_cnt <= la_cnt + 2'd1;
            end
          end
        end
        ST_DECIDE: begin
          if (u_foreign || u_boundary) begin
            ret_final <= 1'b0;
            state     <= ST_FLUSH_PRE;
          end else begin
            state <= ST_ACT;
          end
        end
        ST_FLUSH_PRE: begin
          if (!pre_valid || can_emit) begin
            pre_valid <= 1'b0;
            rd_idx    <= '0;
            if (syl_cnt != '0) begin
              state <= ST_FLUSH_RD;
            end else begin
              state <= ret_final ? ST_FINAL : ST_ACT;
            end
          end
        end
        ST_FLUSH_RD: begin
          state <= ST_FLUSH_EMIT;
        end
        ST_FLUSH_EMIT: begin
          if (can_emit) begin
            if (rd_last) begin
              syl_cnt <= '0;
              state   <= ret_final ? ST_FINAL : ST_ACT;
            end else begin
              rd_idx <= rd_idx + SYL_AW'(1);
              state  <= ST_FLUSH_RD;
            end
          end
        end
        ST_ACT: begin
          if (u_foreign) begin
            if (emit_go) begin
              prev_unit  <= w0;
              prev_valid <= 1'b1;
              w0 <= w1;
              w1 <= w2;
              wn <= wn - 2'd1;
              state <= ST_NEXT;
            end
          end else if (u_kinzi) begin
            if (emit_go) begin
              if (kz_idx == 2'd2) begin
                kz_idx     <= '0;
                prev_unit  <= U_VIRAMA;
                prev_valid <= 1'b1;
                wn         <= '0;
                state      <= ST_NEXT;
              end else begin
                kz_idx <= kz_idx + 2'd1;
              end
            end
          end else if (u_prefix) begin
            pre_unit   <= w0;
            pre_valid  <= 1'b1;
            prev_unit  <= w0;
            prev_valid <= 1'b1;
            w0 <= w1;
            w1 <= w2;
            wn <= wn - 2'd1;
            state <= ST_NEXT;
          end else if (syl_full) begin
            // full body: flush first, the unit then opens the new body
            force_append <= 1'b1;
            ret_final    <= 1'b0;
            state        <= ST_FLUSH_PRE;
          end else begin
            syl_cnt      <= syl_cnt + SYL_CW'(1);
            force_append <= 1'b0;
            prev_unit    <= w0;
            prev_valid   <= 1'b1;
            w0 <= w1;
            w1 <= w2;
            wn <= wn - 2'd1;
            state <= ST_NEXT;
          end
        end
        ST_NEXT: begin
          if (end_flag) begin
            if (wn != 2'd0) begin
              state <= ST_DECIDE;
            end else begin
              ret_final <= 1'b1;
              state     <= ST_FLUSH_PRE;
            end
          end else begin
            la0    <= w0;
            la1    <= w1;
            la_cnt <= wn;
            state  <= ST_FINAL;
          end
        end
        ST_FINAL: begin
          if (!pend_valid || adv) begin
            if (end_flag) begin
              la_cnt     <= '0;
              prev_unit  <= '0;
              prev_valid <= 1'b0;
              pre_valid  <= 1'b0;
              syl_cnt    <= '0;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !pend_valid)
    else $error("held result left over while idle");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    syl_cnt <= SYL_CW'(SYL_DEPTH))
    else $error("syllable count beyond store depth");

  a_forced_append_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ACT && force_append) |-> (syl_cnt == '0))
    else $error("forced append into non-empty body");

  a_window_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DECIDE || state == ST_ACT) |-> (wn != 2'd0))
    else $error("deciding on an empty window");

  a_store_write_room: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> !syl_full && !ram_re)
    else $error("store write while full or during read");

endmodule

FILE: hw/rtl/msr_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module msr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for myanmar_syllable_reorder_unit: directed strings, then random text.
// Depends on msr_pkg (code-unit constants, store depth) and the reorder unit RTL.
module testbench;
  import msr_pkg::*;

  localparam int ITEM_TARGET = 370;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 64;

  typedef logic [15:0] cu_t;
  typedef cu_t window_t [3];

  typedef struct packed {
    cu_t  cu;
    logic last;
    logic done;
  } beat_t;

  typedef enum logic [1:0] {EXP_PREDICT, EXP_NONE, EXP_ONE} exp_kind_t;

  typedef struct packed {
    cu_t       cu;
    logic      eot;
    exp_kind_t kind;
    cu_t       typed_cu;
  } row_t;

  typedef enum int {
    CH_SYLLABLE, CH_KINZI, CH_STACK, CH_LONG, CH_DIGITS, CH_ASCII, CH_NOISE, CH_BROKEN
  } chunk_t;

  logic clk;
  logic rst;
  logic item_valid;
  logic item_ready;
  logic [15:0] code_unit;
  logic end_of_text;
  logic result_valid;
  logic result_ready;
  logic [15:0] out_unit;
  logic last_of_run;
  logic text_done;

  myanmar_syllable_reorder_unit u_dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .code_unit   (code_unit),
    .end_of_text (end_of_text),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .out_unit    (out_unit),
    .last_of_run (last_of_run),
    .text_done   (text_done)
  );

  // ---------------- reorder predictor ----------------
  cu_t   look_q [2];
  int    look_n;
  cu_t   prev_cu;
  bit    prev_ok;
  cu_t   lead_cu;
  bit    lead_ok;
  cu_t   body_q [SYL_DEPTH];
  int    body_n;
  cu_t   burst [$];
  beat_t reorder_q [$];

  function automatic bit is_letter(cu_t u);
    return (u >= U_BLOCK_LO && u <= U_CONS_HI) || u == U_GREAT_SA ||
           (u >= U_DIGIT_LO && u <= U_DIGIT_HI) || u == U_SYM_AFORE;
  endfunction

  function void clear_reorder();
    look_n  = 0;
    prev_cu = '0;
    prev_ok = 0;
    lead_ok = 0;
    body_n  = 0;
  endfunction

  function void dump_syllable();
    if (lead_ok) burst.push_back(lead_cu);
    for (int k = 0; k < body_n; k++) burst.push_back(body_q[k]);
    lead_ok = 0;
    body_n  = 0;
  endfunction

  // settle the unit at w[pos]; n units are known from pos on
  function int settle_unit(window_t w, int pos, int n);
    cu_t u;
    bit  letter;
    bit  kinzi;
    bit  brk;
    u = w[pos];
    if (u < U_BLOCK_LO || u > U_BLOCK_HI) begin
      dump_syllable();
      burst.push_back(u);
      prev_cu = u;
      prev_ok = 1;
      return 1;
    end
    letter = is_letter(u);
    kinzi  = (u == U_NGA) && (n >= 3) && (w[pos+1] == U_ASAT) && (w[pos+2] == U_VIRAMA);
    brk    = 0;
    if (u == U_E_VOWEL || u == U_MEDIAL_RA) begin
      brk = 1;
    end else if (letter) begin
      brk = !kinzi;
      if (prev_ok && prev_cu == U_VIRAMA) brk = 0;
      else if (n >= 2 && w[pos+1] == U_ASAT) brk = 0;
    end
    if (brk) dump_syllable();
    if (kinzi) begin
      burst.push_back(U_NGA);
      burst.push_back(U_ASAT);
      burst.push_back(U_VIRAMA);
      prev_cu = U_VIRAMA;
      prev_ok = 1;
      return 3;
    end
    if (letter && !lead_ok) begin
      lead_cu = u;
      lead_ok = 1;
    end else begin
      // full body goes out first, the unit starts a new one
      if (body_n >= SYL_DEPTH) dump_syllable();
      body_q[body_n] = u;
      body_n++;
    end
    prev_cu = u;
    prev_ok = 1;
    return 1;
  endfunction

  // leaves the units caused by one input beat in burst
  function void reorder_beat(cu_t cu, bit eot);
    window_t w;
    int n;
    int pos;
    int used;
    burst.delete();
    n = 0;
    if (look_n >= 1) begin w[n] = look_q[0]; n++; end
    if (look_n >= 2) begin w[n] = look_q[1]; n++; end
    w[n] = cu;
    n++;
    if (eot) begin
      pos = 0;
      while (pos < n) pos += settle_unit(w, pos, n - pos);
      dump_syllable();
      clear_reorder();
    end else if (n == 3) begin
      used = settle_unit(w, 0, 3);
      look_n = 3 - used;
      for (int k = 0; k < 3 - used; k++) look_q[k] = w[used + k];
    end else begin
      for (int k = 0; k < n; k++) look_q[k] = w[k];
      look_n = n;
    end
  endfunction

  // ---------------- clock, ready, checking ----------------
  bit no_idle;
  int n_items;
  int n_texts;
  int n_results;
  int n_errors;
  int stall_cycles;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    result_ready <= no_idle || ($urandom_range(0, 99) >= 8);
  end

  always @(posedge clk) begin
    beat_t got;
    beat_t want;
    got = '{out_unit, last_of_run, text_done};
    if (!rst && result_valid && result_ready) begin
      n_results++;
      if (reorder_q.size() == 0) begin
        if (n_errors < 10)
          $display("ERROR: unexpected beat unit=%h last=%b done=%b", got.cu, got.last,
                   got.done);
        n_errors++;
      end else begin
        want = reorder_q.pop_front();
        if (got != want) begin
          if (n_errors < 10)
            $display("ERROR: beat %0d expected unit=%h last=%b done=%b, got unit=%h last=%b done=%b",
                     n_results, want.cu, want.last, want.done, got.cu, got.last, got.done);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
      $display("myanmar_syllable_reorder_unit verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------- stimulus ----------------
  // called just after a falling edge; returns just after a falling edge once the unit has been taken
  task automatic send_unit(cu_t cu, bit eot, exp_kind_t kind, cu_t typed_cu);
    while (!no_idle && $urandom_range(0, 99) < 8) begin
      item_valid = 0;
      @(negedge clk);
    end
    item_valid  = 1;
    code_unit   = cu;
    end_of_text = eot;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    n_items++;
    if (eot) n_texts++;
    reorder_beat(cu, eot);
    if (kind == EXP_PREDICT) begin
      foreach (burst[i])
        reorder_q.push_back('{burst[i], i == burst.size() - 1, eot && i == burst.size() - 1});
    end else if (kind == EXP_ONE) begin
      reorder_q.push_back('{typed_cu, 1'b1, eot});
    end
    @(negedge clk);
  endtask

  function automatic cu_t rand_letter();
    case ($urandom_range(0, 7))
      0:       return U_GREAT_SA;
      1:       return cu_t'($urandom_range(U_DIGIT_LO, U_DIGIT_HI));
      2:       return U_SYM_AFORE;
      default: return cu_t'($urandom_range(U_BLOCK_LO, U_CONS_HI));
    endcase
  endfunction

  function automatic cu_t rand_sign();
    if ($urandom_range(0, 4) == 4) return cu_t'($urandom_range(16'h104A, U_BLOCK_HI));
    return cu_t'($urandom_range(16'h102B, 16'h103E));
  endfunction

  row_t plan [25] = '{
    '{16'h0000, 1'b1, EXP_ONE, 16'h0000},
    '{16'hFFFF, 1'b1, EXP_ONE, 16'hFFFF},
    '{16'h1000, 1'b1, EXP_ONE, 16'h1000},
    '{16'h109F, 1'b1, EXP_ONE, 16'h109F},
    // e-vowel and medial ra ahead of their consonants
    '{16'h1031, 1'b0, EXP_NONE, 16'h0},
    '{16'h1000, 1'b0, EXP_NONE, 16'h0},
    '{16'h103C, 1'b0, EXP_PREDICT, 16'h0},
    '{16'h1019, 1'b1, EXP_PREDICT, 16'h0},
    // kinzi, then a consonant stacked under it
    '{16'h1004, 1'b0, EXP_NONE, 16'h0},
    '{16'h103A, 1'b0, EXP_NONE, 16'h0},
    '{16'h1039, 1'b0, EXP_PREDICT, 16'h0},
    '{16'h1000, 1'b1, EXP_PREDICT, 16'h0},
    // killed consonant
    '{16'h1000, 1'b0, EXP_NONE, 16'h0},
    '{16'h1014, 1'b0, EXP_NONE, 16'h0},
    '{16'h103A, 1'b1, EXP_PREDICT, 16'h0},
    // nga asat cut short by the end of text: no kinzi
    '{16'h1004, 1'b0, EXP_NONE, 16'h0},
    '{16'h103A, 1'b1, EXP_PREDICT, 16'h0},
    // stacked consonant
    '{16'h1000, 1'b0, EXP_NONE, 16'h0},
    '{16'h1039, 1'b0, EXP_NONE, 16'h0},
    '{16'h1001, 1'b1, EXP_PREDICT, 16'h0},
    '{16'h1049, 1'b0, EXP_NONE, 16'h0},
    '{16'h104E, 1'b0, EXP_NONE, 16'h0},
    '{16'h103F, 1'b0, EXP_PREDICT, 16'h0},
    '{16'h0FFF, 1'b0, EXP_PREDICT, 16'h0},
    '{16'h10A0, 1'b1, EXP_PREDICT, 16'h0}
  };

  initial begin
    cu_t    txt [$];
    cu_t    u;
    chunk_t kind;
    int     pick;
    rst          = 1;
    item_valid   = 0;
    code_unit    = '0;
    end_of_text  = 0;
    result_ready = 0;
    no_idle      = 0;
    n_items      = 0;
    n_texts      = 0;
    n_results    = 0;
    n_errors     = 0;
    stall_cycles = 0;
    clear_reorder();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 0;

    foreach (plan[i]) send_unit(plan[i].cu, plan[i].eot, plan[i].kind, plan[i].typed_cu);

    while (n_items < ITEM_TARGET) begin
      txt.delete();
      repeat ($urandom_range(1, 6)) begin
        pick = $urandom_range(0, 9);
        kind = (pick < 3) ? CH_SYLLABLE : chunk_t'(pick - 2);
        case (kind)
          CH_SYLLABLE: begin
            case ($urandom_range(0, 3))
              0: txt.push_back(U_E_VOWEL);
              1: txt.push_back(U_MEDIAL_RA);
              default: ;
            endcase
            txt.push_back(rand_letter());
            repeat ($urandom_range(0, 3)) txt.push_back(rand_sign());
            if ($urandom_range(0, 2) == 0) begin
              txt.push_back(rand_letter());
              txt.push_back(U_ASAT);
            end
          end
          CH_KINZI: begin
            txt.push_back(U_NGA);
            txt.push_back(U_ASAT);
            txt.push_back(U_VIRAMA);
            txt.push_back(rand_letter());
            if ($urandom_range(0, 1)) txt.push_back(rand_sign());
          end
          CH_STACK: begin
            txt.push_back(rand_letter());
            txt.push_back(U_VIRAMA);
            txt.push_back(rand_letter());
          end
          CH_LONG: begin
            // body units from one under to four over the store depth, so the store often overflows
            txt.push_back(rand_letter());
            repeat ($urandom_range(SYL_DEPTH - 1, SYL_DEPTH + 4)) begin
              u = cu_t'($urandom_range(16'h102B, 16'h1038));
              txt.push_back((u == U_E_VOWEL) ? 16'h1032 : u);
            end
          end
          CH_DIGITS: begin
            repeat ($urandom_range(1, 3))
              txt.push_back(cu_t'($urandom_range(U_DIGIT_LO, U_DIGIT_HI)));
          end
          CH_ASCII: txt.push_back(cu_t'($urandom_range(32, 126)));
          CH_NOISE: txt.push_back(cu_t'($urandom_range(0, 16'hFFFF)));
          default: begin
            repeat ($urandom_range(1, 4))
              txt.push_back(cu_t'($urandom_range(U_BLOCK_LO, U_BLOCK_HI)));
          end
        endcase
      end
      // a long run with both sides always willing
      no_idle = (n_items >= 150) && (n_items < 250);
      foreach (txt[i]) send_unit(txt[i], i == txt.size() - 1, EXP_PREDICT, '0);
    end

    no_idle    = 0;
    item_valid = 0;
    while (reorder_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run: %0d code units in %0d strings (kinzi, stacking, killed, store overflow, noise)",
             n_items, n_texts);
    $display("run: %0d output beats checked, %0d mismatches", n_results, n_errors);
    if (n_errors == 0) begin
      $display("myanmar_syllable_reorder_unit verification clean");
    end else begin
      $display("myanmar_syllable_reorder_unit verification failed");
    end
    $finish;
  end

endmodule
